### src/sqvs_pkg.sv
package sqvs_pkg;

    // Default fixed-point formats
    localparam int POS_FRAC_BITS  = 4;
    localparam int TRIG_FRAC_BITS = 14;

    // Configuration register indexes
    localparam logic [1:0] CFG_SHEET_W = 2'd0;
    localparam logic [1:0] CFG_SHEET_H = 2'd1;
    localparam logic [1:0] CFG_COLOR   = 2'd2;

    localparam logic [12:0] SHEET_RESET = 13'd1024;
    localparam logic [31:0] COLOR_RESET = 32'hFFFF_FFFF;

    // Scale clamp, Q4.8
    localparam logic [11:0] SCALE_MIN = 12'd26;
    localparam logic [11:0] SCALE_MAX = 12'd2559;

    // Angle reduction: bias to positive, then divide by 360 with a reciprocal
    localparam int          DEG_FULL   = 360;
    localparam int          DEG_HALF   = 180;
    localparam int          DEG_QUART  = 90;
    localparam int          ANG_BIAS   = 33120;
    localparam int          ANG_RECIP  = 93207;
    localparam int          ANG_SHIFT  = 25;

    // Texture divider
    localparam int          DEN_W      = 13;
    localparam int          QUO_W      = 16;
    localparam int          DIV_STEP   = 4;
    localparam int          DIV_LEVELS = QUO_W / DIV_STEP;
    localparam int          TEX_W      = 17;
    localparam logic [16:0] TEX_ONE    = 17'h1_0000;

    // Vertex sequencing
    localparam logic [2:0]  LAST_SLOT  = 3'd5;

    // Lanes of the texture divider
    localparam int LANE_UL = 0;
    localparam int LANE_UR = 1;
    localparam int LANE_VB = 2;
    localparam int LANE_VT = 3;

    // Quarter-wave sine, Q1.14
    localparam logic [14:0] SIN_Q14 [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
        15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
        15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
        15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
        15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
        15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
        15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
        15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
        15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
        15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
        15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
    };

    // One sprite's finished corners and raw texture quotients
    typedef struct packed {
        logic [3:0][15:0] vx;
        logic [3:0][15:0] vy;
        logic [3:0][15:0] quo;
        logic [3:0]       ge;
    } t_quad;

    // Table magnitude rescaled to t fraction bits, rounded half up
    function automatic int trig_mag(input logic [6:0] idx, input int t);
        int m;
        m = int'(SIN_Q14[idx]);
        if (t >= 14) begin
            m = m << (t - 14);
        end else begin
            m = (m + (1 << (13 - t))) >> (14 - t);
        end
        return m;
    endfunction

    // Sine of a whole-degree angle 0..359
    function automatic logic signed [17:0] sin_deg(input logic [8:0] a, input int t);
        logic [8:0] idx;
        logic       neg;
        int         m;
        neg = 1'b0;
        if (a <= 9'(DEG_QUART)) begin
            idx = a;
        end else if (a <= 9'(DEG_HALF)) begin
            idx = 9'(DEG_HALF) - a;
        end else if (a <= 9'(DEG_HALF + DEG_QUART)) begin
            idx = a - 9'(DEG_HALF);
            neg = 1'b1;
        end else begin
            idx = 9'(DEG_FULL) - a;
            neg = 1'b1;
        end
        m = trig_mag(idx[6:0], t);
        return neg ? -18'(m) : 18'(m);
    endfunction

    // Quad corner used by each of the six vertex slots
    function automatic logic [1:0] slot_point(input logic [2:0] slot);
        logic [1:0] p;
        unique case (slot)
            3'd0:    p = 2'd0;
            3'd1:    p = 2'd1;
            3'd2:    p = 2'd2;
            3'd3:    p = 2'd2;
            3'd4:    p = 2'd3;
            default: p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

### src/sprite_quad_vertex_setup.sv
// Sprite quad vertex setup.
// Command channel: drive the sprite fields with start high; the sprite is taken
// at a clock edge where start is high and busy is low. Each sprite produces six
// vertices (two triangles, corners p0 p1 p2 p2 p3 p0), one per cycle, each shown
// for one cycle with o_vertex_valid high; o_corner counts 0..5 and o_last marks
// the sixth. The receiver cannot stall, so results are never held.
// An accepted sprite passes through the six front-end stages and then the vertex
// sequencer's quad register before its first vertex is shown.
// Sprites can follow back to back, paced by the single vertex output port;
// the six-stage front end accepts a sprite every cycle until it backs up, then
// busy rises until the vertex sequencer frees a slot.
// Configuration: write sheet width (index 0), sheet height (1) or vertex color
// (2) through i_cfg_we/i_cfg_idx/i_cfg_data while no sprite is in flight.
// Reset (synchronous, active low) empties the pipeline and restores sheet sizes
// of 1024 and a color of all ones.
module sprite_quad_vertex_setup #(
    parameter int POS_FRAC_BITS  = sqvs_pkg::POS_FRAC_BITS,
    parameter int TRIG_FRAC_BITS = sqvs_pkg::TRIG_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [11:0]        i_atlas_x,
    input  logic [11:0]        i_atlas_y,
    input  logic [11:0]        i_sprite_width,
    input  logic [11:0]        i_sprite_height,
    input  logic signed [15:0] i_offset_x,
    input  logic signed [15:0] i_offset_y,
    input  logic [11:0]        i_scale,
    input  logic signed [15:0] i_angle,
    output logic               o_vertex_valid,
    output logic signed [15:0] o_vertex_x,
    output logic signed [15:0] o_vertex_y,
    output logic [16:0]        o_tex_u,
    output logic [16:0]        o_tex_v,
    output logic [31:0]        o_color,
    output logic [2:0]         o_corner,
    output logic               o_last
);

    localparam int HS     = 9 - POS_FRAC_BITS;
    localparam int HX_RND = 1 << (HS - 1);
    localparam int HALF_W = 25 - HS;
    localparam int D_W    = HALF_W + 2;
    localparam int TRIG_W = TRIG_FRAC_BITS + 2;
    localparam int PROD_W = D_W + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SAT_W  = SUM_W + 1;
    localparam int T_RND  = 1 << (TRIG_FRAC_BITS - 1);
    localparam int NSTG   = 6;

    localparam logic signed [SAT_W-1:0] POS_MAX = SAT_W'(32767);
    localparam logic signed [SAT_W-1:0] POS_MIN = -SAT_W'(32768);

    function automatic logic signed [15:0] sat16(input logic signed [SAT_W-1:0] v);
        logic signed [15:0] r;
        if (v > POS_MAX) begin
            r = 16'sh7FFF;
        end else if (v < POS_MIN) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Configuration registers
    logic [12:0] r_sheet_w;
    logic [12:0] r_sheet_h;
    logic [31:0] r_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sheet_w <= sqvs_pkg::SHEET_RESET;
            r_sheet_h <= sqvs_pkg::SHEET_RESET;
            r_color   <= sqvs_pkg::COLOR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sqvs_pkg::CFG_SHEET_W: r_sheet_w <= i_cfg_data[12:0];
                sqvs_pkg::CFG_SHEET_H: r_sheet_h <= i_cfg_data[12:0];
                sqvs_pkg::CFG_COLOR:   r_color   <= i_cfg_data;
                default:               r_color   <= r_color;
            endcase
        end
    end

    // A zero sheet size acts as one; rounding term is half the divisor
    logic [12:0] den_w, den_h;
    logic [15:0] low_w, low_h;
    assign den_w = (r_sheet_w == 13'd0) ? 13'd1 : r_sheet_w;
    assign den_h = (r_sheet_h == 13'd0) ? 13'd1 : r_sheet_h;
    assign low_w = 16'(den_w >> 1);
    assign low_h = 16'(den_h >> 1);

    // ---------------------------------------------------------------------
    // Stage enables: a stage moves when empty or when the next one moves
    logic [NSTG:1] r_v;
    logic [NSTG:1] en;
    logic          emit_take;

    always_comb begin
        en[NSTG] = !r_v[NSTG] || emit_take;
        for (int k = NSTG - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign busy = !en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= start;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: capture the command
    logic signed [15:0] r1_px, r1_py, r1_ox, r1_oy, r1_ang;
    logic [11:0]        r1_ax, r1_ay, r1_w, r1_h, r1_sc;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_px  <= i_pos_x;
            r1_py  <= i_pos_y;
            r1_ax  <= i_atlas_x;
            r1_ay  <= i_atlas_y;
            r1_w   <= i_sprite_width;
            r1_h   <= i_sprite_height;
            r1_ox  <= i_offset_x;
            r1_oy  <= i_offset_y;
            r1_sc  <= i_scale;
            r1_ang <= i_angle;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: scale the size, start the angle reduction, set up numerators
    logic [11:0]        s2_sc;
    logic signed [17:0] s2_ub;
    logic [33:0]        s2_qm;
    logic [3:0][12:0]   s2_num;
    logic [3:0]         s2_ge;

    always_comb begin
        if (r1_sc < sqvs_pkg::SCALE_MIN) begin
            s2_sc = sqvs_pkg::SCALE_MIN;
        end else if (r1_sc > sqvs_pkg::SCALE_MAX) begin
            s2_sc = sqvs_pkg::SCALE_MAX;
        end else begin
            s2_sc = r1_sc;
        end
        s2_ub = 18'(r1_ang) + 18'(sqvs_pkg::ANG_BIAS);
        s2_qm = 34'(s2_ub[16:0]) * 34'(sqvs_pkg::ANG_RECIP);
        s2_num[sqvs_pkg::LANE_UL] = 13'(r1_ax);
        s2_num[sqvs_pkg::LANE_UR] = 13'(r1_ax) + 13'(r1_w);
        s2_num[sqvs_pkg::LANE_VB] = 13'(r1_ay);
        s2_num[sqvs_pkg::LANE_VT] = 13'(r1_ay) + 13'(r1_h);
        s2_ge[sqvs_pkg::LANE_UL]  = s2_num[sqvs_pkg::LANE_UL] >= den_w;
        s2_ge[sqvs_pkg::LANE_UR]  = s2_num[sqvs_pkg::LANE_UR] >= den_w;
        s2_ge[sqvs_pkg::LANE_VB]  = s2_num[sqvs_pkg::LANE_VB] >= den_h;
        s2_ge[sqvs_pkg::LANE_VT]  = s2_num[sqvs_pkg::LANE_VT] >= den_h;
    end

    logic [23:0]        r2_mw, r2_mh;
    logic [16:0]        r2_u;
    logic [8:0]         r2_qa;
    logic signed [15:0] r2_px, r2_py, r2_ox, r2_oy;
    logic [3:0][12:0]   r2_num;
    logic [3:0]         r2_ge;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_mw  <= 24'(r1_w) * 24'(s2_sc);
            r2_mh  <= 24'(r1_h) * 24'(s2_sc);
            r2_u   <= s2_ub[16:0];
            r2_qa  <= s2_qm[sqvs_pkg::ANG_SHIFT+8:sqvs_pkg::ANG_SHIFT];
            r2_px  <= r1_px;
            r2_py  <= r1_py;
            r2_ox  <= r1_ox;
            r2_oy  <= r1_oy;
            r2_num <= s2_num;
            r2_ge  <= s2_ge;
        end
    end

    // ---------------------------------------------------------------------
    // Texture divider lanes, stages 3 to 6
    logic [3:0][sqvs_pkg::DIV_LEVELS-1:0][12:0] div_rem;
    logic [3:0][sqvs_pkg::DIV_LEVELS-1:0][15:0] div_quo;

    for (genvar l = 0; l < 4; l++) begin : g_lane
        for (genvar j = 0; j < sqvs_pkg::DIV_LEVELS; j++) begin : g_lvl
            logic [12:0] rem_in;
            logic [15:0] quo_in;
            if (j == 0) begin : g_first
                assign rem_in = r2_num[l];
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = div_rem[l][j-1];
                assign quo_in = div_quo[l][j-1];
            end
            sqvs_div_step #(
                .FIRST_BIT(sqvs_pkg::QUO_W - 1 - j * sqvs_pkg::DIV_STEP)
            ) u_step (
                .i_clk (i_clk),
                .i_en  (en[3+j]),
                .i_den ((l < 2) ? den_w : den_h),
                .i_low ((l < 2) ? low_w : low_h),
                .i_rem (rem_in),
                .i_quo (quo_in),
                .o_rem (div_rem[l][j]),
                .o_quo (div_quo[l][j])
            );
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: half sizes, corners, deltas to the rotation center, angle
    logic [24:0]             s3_hxs, s3_hys;
    logic [HALF_W-1:0]       s3_hx, s3_hy;
    logic signed [D_W-1:0]   s3_hxe, s3_hye;
    logic [17:0]             s3_rm;

    always_comb begin
        s3_hxs = 25'(r2_mw) + 25'(HX_RND);
        s3_hys = 25'(r2_mh) + 25'(HX_RND);
        s3_hx  = HALF_W'(s3_hxs >> HS);
        s3_hy  = HALF_W'(s3_hys >> HS);
        s3_hxe = D_W'($signed({1'b0, s3_hx}));
        s3_hye = D_W'($signed({1'b0, s3_hy}));
        s3_rm  = 18'(r2_u) - 18'(r2_qa) * 18'(sqvs_pkg::DEG_FULL);
    end

    logic [8:0]                 r3_ang;
    logic signed [16:0]         r3_cx, r3_cy;
    logic signed [1:0][D_W-1:0] r3_dx, r3_dy, r3_x, r3_y;
    logic [3:0]                 r3_ge;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_ang   <= s3_rm[8:0];
            r3_cx    <= 17'(r2_px) + 17'(r2_ox);
            r3_cy    <= 17'(r2_py) + 17'(r2_oy);
            r3_dx[0] <= -s3_hxe - D_W'(r2_ox);
            r3_dx[1] <= s3_hxe - D_W'(r2_ox);
            r3_dy[0] <= -s3_hye - D_W'(r2_oy);
            r3_dy[1] <= s3_hye - D_W'(r2_oy);
            r3_x[0]  <= D_W'(r2_px) - s3_hxe;
            r3_x[1]  <= D_W'(r2_px) + s3_hxe;
            r3_y[0]  <= D_W'(r2_py) - s3_hye;
            r3_y[1]  <= D_W'(r2_py) + s3_hye;
            r3_ge    <= r2_ge;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 4: sine and cosine lookup
    logic [9:0] s4_cb;
    logic [8:0] s4_ca;

    always_comb begin
        s4_cb = 10'(r3_ang) + 10'(sqvs_pkg::DEG_QUART);
        s4_ca = (s4_cb >= 10'(sqvs_pkg::DEG_FULL)) ? 9'(s4_cb - 10'(sqvs_pkg::DEG_FULL))
                                                    : s4_cb[8:0];
    end

    logic signed [TRIG_W-1:0]   r4_sin, r4_cos;
    logic                       r4_rot;
    logic signed [16:0]         r4_cx, r4_cy;
    logic signed [1:0][D_W-1:0] r4_dx, r4_dy, r4_x, r4_y;
    logic [3:0]                 r4_ge;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_sin <= TRIG_W'(sqvs_pkg::sin_deg(r3_ang, TRIG_FRAC_BITS));
            r4_cos <= TRIG_W'(sqvs_pkg::sin_deg(s4_ca, TRIG_FRAC_BITS));
            r4_rot <= (r3_ang != 9'd0);
            r4_cx  <= r3_cx;
            r4_cy  <= r3_cy;
            r4_dx  <= r3_dx;
            r4_dy  <= r3_dy;
            r4_x   <= r3_x;
            r4_y   <= r3_y;
            r4_ge  <= r3_ge;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 5: rotation products, each x and y offset times sine and cosine
    logic signed [1:0][PROD_W-1:0] r5_xc, r5_ys, r5_xs, r5_yc;
    logic                          r5_rot;
    logic signed [16:0]            r5_cx, r5_cy;
    logic signed [1:0][D_W-1:0]    r5_x, r5_y;
    logic [3:0]                    r5_ge;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            for (int i = 0; i < 2; i++) begin
                r5_xc[i] <= PROD_W'($signed(r4_dx[i])) * PROD_W'(r4_cos);
                r5_ys[i] <= PROD_W'($signed(r4_dy[i])) * PROD_W'(r4_sin);
                r5_xs[i] <= PROD_W'($signed(r4_dx[i])) * PROD_W'(r4_sin);
                r5_yc[i] <= PROD_W'($signed(r4_dy[i])) * PROD_W'(r4_cos);
            end
            r5_rot <= r4_rot;
            r5_cx  <= r4_cx;
            r5_cy  <= r4_cy;
            r5_x   <= r4_x;
            r5_y   <= r4_y;
            r5_ge  <= r4_ge;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 6: round and recenter each rotated corner, or keep the plain corner; saturate
    logic [3:0][15:0] s6_vx, s6_vy;

    always_comb begin
        logic signed [SUM_W-1:0] xs, ys;
        logic signed [SAT_W-1:0] xf, yf;
        int                      i, j;
        for (int k = 0; k < 4; k++) begin
            i  = (k == 1 || k == 2) ? 1 : 0;
            j  = (k >= 2) ? 1 : 0;
            xs = SUM_W'($signed(r5_xc[i])) - SUM_W'($signed(r5_ys[j])) + SUM_W'(T_RND);
            ys = SUM_W'($signed(r5_xs[i])) + SUM_W'($signed(r5_yc[j])) + SUM_W'(T_RND);
            xf = SAT_W'(xs >>> TRIG_FRAC_BITS) + SAT_W'(r5_cx);
            yf = SAT_W'(ys >>> TRIG_FRAC_BITS) + SAT_W'(r5_cy);
            if (r5_rot) begin
                s6_vx[k] = sat16(xf);
                s6_vy[k] = sat16(yf);
            end else begin
                s6_vx[k] = sat16(SAT_W'($signed(r5_x[i])));
                s6_vy[k] = sat16(SAT_W'($signed(r5_y[j])));
            end
        end
    end

    logic [3:0][15:0] r6_vx, r6_vy;
    logic [3:0]       r6_ge;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_vx <= s6_vx;
            r6_vy <= s6_vy;
            r6_ge <= r5_ge;
        end
    end

    // ---------------------------------------------------------------------
    // Vertex sequencer
    sqvs_pkg::t_quad quad;

    always_comb begin
        quad.vx = r6_vx;
        quad.vy = r6_vy;
        quad.ge = r6_ge;
        for (int l = 0; l < 4; l++) begin
            quad.quo[l] = div_quo[l][sqvs_pkg::DIV_LEVELS-1];
        end
    end

    sqvs_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_v[NSTG]),
        .i_quad         (quad),
        .i_color        (r_color),
        .o_take         (emit_take),
        .o_vertex_valid (o_vertex_valid),
        .o_vertex_x     (o_vertex_x),
        .o_vertex_y     (o_vertex_y),
        .o_tex_u        (o_tex_u),
        .o_tex_v        (o_tex_v),
        .o_color        (o_color),
        .o_corner       (o_corner),
        .o_last         (o_last)
    );

endmodule

### src/sqvs_div_step.sv
module sqvs_div_step #(
    parameter int FIRST_BIT = 15
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [sqvs_pkg::DEN_W-1:0]    i_den,
    input  logic [sqvs_pkg::QUO_W-1:0]    i_low,
    input  logic [sqvs_pkg::DEN_W-1:0]    i_rem,
    input  logic [sqvs_pkg::QUO_W-1:0]    i_quo,
    output logic [sqvs_pkg::DEN_W-1:0]    o_rem,
    output logic [sqvs_pkg::QUO_W-1:0]    o_quo
);

    logic [sqvs_pkg::DEN_W-1:0] r_rem;
    logic [sqvs_pkg::QUO_W-1:0] r_quo;
    logic [sqvs_pkg::DEN_W-1:0] n_rem;
    logic [sqvs_pkg::QUO_W-1:0] n_quo;

    // Restoring division, DIV_STEP (four) quotient bits per stage
    always_comb begin
        logic [sqvs_pkg::DEN_W:0] r;
        r     = {1'b0, i_rem};
        n_quo = i_quo;
        for (int k = 0; k < sqvs_pkg::DIV_STEP; k++) begin
            r = {r[sqvs_pkg::DEN_W-1:0], i_low[FIRST_BIT-k]};
            if (r >= {1'b0, i_den}) begin
                r     = r - {1'b0, i_den};
                n_quo = {n_quo[sqvs_pkg::QUO_W-2:0], 1'b1};
            end else begin
                n_quo = {n_quo[sqvs_pkg::QUO_W-2:0], 1'b0};
            end
        end
        n_rem = r[sqvs_pkg::DEN_W-1:0];
    end

    // Advance with the pipeline
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

### src/sqvs_emit.sv
module sqvs_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  sqvs_pkg::t_quad               i_quad,
    input  logic [31:0]                   i_color,
    output logic                          o_take,
    output logic                          o_vertex_valid,
    output logic signed [15:0]            o_vertex_x,
    output logic signed [15:0]            o_vertex_y,
    output logic [16:0]                   o_tex_u,
    output logic [16:0]                   o_tex_v,
    output logic [31:0]                   o_color,
    output logic [2:0]                    o_corner,
    output logic                          o_last
);

    sqvs_pkg::t_quad r_quad;
    logic            r_busy;
    logic [2:0]      r_slot;
    logic [1:0]      pt;
    logic [3:0][16:0] tex;

    // Take a new sprite when idle or on the last beat
    assign o_take = !r_busy || (r_slot == sqvs_pkg::LAST_SLOT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= 3'd0;
        end else if (o_take) begin
            r_busy <= i_valid;
            r_slot <= 3'd0;
        end else begin
            r_slot <= r_slot + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_quad <= i_quad;
        end
    end

    // Finish texture coordinates: saturate u, flip and clamp v
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            if (l == sqvs_pkg::LANE_UL || l == sqvs_pkg::LANE_UR) begin
                tex[l] = r_quad.ge[l] ? sqvs_pkg::TEX_ONE : {1'b0, r_quad.quo[l]};
            end else begin
                tex[l] = r_quad.ge[l] ? 17'd0 : sqvs_pkg::TEX_ONE - {1'b0, r_quad.quo[l]};
            end
        end
    end

    // Select the corner for this beat
    assign pt             = sqvs_pkg::slot_point(r_slot);
    assign o_vertex_valid = r_busy;
    assign o_vertex_x     = r_quad.vx[pt];
    assign o_vertex_y     = r_quad.vy[pt];
    assign o_tex_u        = (pt == 2'd0 || pt == 2'd3) ? tex[sqvs_pkg::LANE_UL]
                                                       : tex[sqvs_pkg::LANE_UR];
    assign o_tex_v        = (pt == 2'd0 || pt == 2'd1) ? tex[sqvs_pkg::LANE_VT]
                                                       : tex[sqvs_pkg::LANE_VB];
    assign o_color        = i_color;
    assign o_corner       = r_slot;
    assign o_last         = r_busy && (r_slot == sqvs_pkg::LAST_SLOT);

endmodule

### src/sqvs_checker.sv
module sqvs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_vertex_valid,
    input logic [2:0]  o_corner,
    input logic        o_last,
    input logic [31:0] o_color
);

    // Nothing comes out the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_vertex_valid)
        else $error("vertex beat right after reset");

    // Last flag exactly on the sixth beat
    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vertex_valid |-> (o_last == (o_corner == 3'd5)))
        else $error("last flag does not match corner");

    // A sprite's six beats come back to back
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vertex_valid && !o_last |=>
            o_vertex_valid && (o_corner == $past(o_corner) + 3'd1))
        else $error("vertex burst broken");

    // A burst that follows an idle cycle starts at corner zero
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vertex_valid && !$past(o_vertex_valid) |-> (o_corner == 3'd0))
        else $error("burst does not start at corner zero");

    // Color holds across a sprite
    a_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vertex_valid && !o_last |=> $stable(o_color))
        else $error("color changed within a sprite");

endmodule

bind sprite_quad_vertex_setup sqvs_checker u_sqvs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_vertex_valid (o_vertex_valid),
    .o_corner       (o_corner),
    .o_last         (o_last),
    .o_color        (o_color)
);
